### rtl/fwb_pkg.sv
package fwb_pkg;

	localparam int MAX_TAPS  = 4096;
	localparam int ADDR_W    = $clog2(MAX_TAPS);
	localparam int TAPS_W    = $clog2(MAX_TAPS + 1);
	localparam int TAP_CNT_W = 13;
	localparam int IDX_W     = 12;
	localparam int SAMPLE_W  = 24;
	localparam int COEF_W    = 18;
	localparam int FRAC_W    = 17;
	localparam int PROD_W    = SAMPLE_W + COEF_W;
	localparam int ACC_W     = PROD_W + ADDR_W;
	localparam int Q_W       = ACC_W - FRAC_W;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef struct packed {
		logic              dl_wr;
		logic [ADDR_W-1:0] wr_slot;
		logic              cf_wr;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_slot;
		logic [ADDR_W-1:0] rd_tap;
		logic              acc_clr;
		logic              res_ld;
		logic              res_warm;
	} fwb_cmd_t;

	typedef struct packed {
		logic pipe_busy;
	} fwb_sts_t;

endpackage

### rtl/fwb_ctrl.sv
module fwb_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         cmd,
	input  logic                         first_of_series,
	output logic                         out_valid,
	input  logic                         out_stall,
	input  logic                         cfg_wr_en,
	input  logic [fwb_pkg::TAP_CNT_W-1:0] cfg_wr_data,
	output fwb_pkg::fwb_cmd_t            dp_cmd,
	input  fwb_pkg::fwb_sts_t            dp_sts
);
	import fwb_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RUN   = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} fwb_state_t;

	fwb_state_t            state_q;
	fwb_state_t            state_d;
	logic [TAP_CNT_W-1:0]  tap_count_q;
	logic [ADDR_W-1:0]     wp_q;
	logic [TAPS_W-1:0]     seen_q;
	logic [ADDR_W-1:0]     slot_q;
	logic [ADDR_W-1:0]     tap_q;
	logic [ADDR_W-1:0]     tap_last_q;
	logic                  warm_q;
	logic                  out_valid_q;

	logic                  accept;
	logic                  smp_acc;
	logic [TAPS_W-1:0]     taps_eff;
	logic [TAPS_W-1:0]     seen_base;
	logic [TAPS_W-1:0]     seen_new;
	logic                  warm;
	logic                  out_free;

	assign accept   = in_valid && !in_stall;
	assign smp_acc  = accept && (cmd == CMD_SAMPLE);
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		if (tap_count_q == '0) begin
			taps_eff = TAPS_W'(1);
		end else if (32'(tap_count_q) > 32'(MAX_TAPS)) begin
			taps_eff = TAPS_W'(MAX_TAPS);
		end else begin
			taps_eff = TAPS_W'(tap_count_q);
		end
		seen_base = first_of_series ? '0 : seen_q;
		seen_new  = (seen_base < TAPS_W'(MAX_TAPS)) ? seen_base + 1'b1 : seen_base;
		warm      = (seen_new < taps_eff);
	end

	always_comb begin
		state_d          = state_q;
		dp_cmd           = '0;
		dp_cmd.wr_slot   = wp_q;
		dp_cmd.rd_slot   = slot_q;
		dp_cmd.rd_tap    = tap_q;
		dp_cmd.res_warm  = warm_q;
		case (state_q)
			S_IDLE: begin
				dp_cmd.cf_wr = accept && (cmd == CMD_LOAD);
				if (smp_acc) begin
					dp_cmd.dl_wr   = 1'b1;
					dp_cmd.acc_clr = 1'b1;
					state_d        = warm ? S_DONE : S_RUN;
				end
			end
			S_RUN: begin
				dp_cmd.rd_en = 1'b1;
				if (tap_q == tap_last_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!dp_sts.pipe_busy) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					dp_cmd.res_ld = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tap_count_q <= TAP_CNT_W'(1);
			wp_q        <= '0;
			seen_q      <= '0;
			slot_q      <= '0;
			tap_q       <= '0;
			tap_last_q  <= '0;
			warm_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				tap_count_q <= cfg_wr_data;
			end
			if (smp_acc) begin
				seen_q     <= seen_new;
				wp_q       <= (wp_q == ADDR_W'(MAX_TAPS - 1)) ? '0 : wp_q + 1'b1;
				slot_q     <= wp_q;
				tap_q      <= '0;
				tap_last_q <= ADDR_W'(taps_eff - 1'b1);
				warm_q     <= warm;
			end else if (dp_cmd.rd_en) begin
				slot_q <= (slot_q == '0) ? ADDR_W'(MAX_TAPS - 1) : slot_q - 1'b1;
				tap_q  <= tap_q + 1'b1;
			end
			if (dp_cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/fwb_datapath.sv
module fwb_datapath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fwb_pkg::fwb_cmd_t                  dp_cmd,
	output fwb_pkg::fwb_sts_t                  dp_sts,
	input  logic signed [fwb_pkg::SAMPLE_W-1:0] sample,
	input  logic        [fwb_pkg::IDX_W-1:0]    coef_index,
	input  logic signed [fwb_pkg::COEF_W-1:0]   coef_value,
	output logic signed [fwb_pkg::SAMPLE_W-1:0] filtered,
	output logic                               warming_up,
	output logic                               saturated
);
	import fwb_pkg::*;

	logic signed [SAMPLE_W-1:0] dl_mem [MAX_TAPS];
	logic signed [COEF_W-1:0]   cf_mem [MAX_TAPS];

	logic signed [SAMPLE_W-1:0] dl_s1;
	logic signed [COEF_W-1:0]   cf_s1;
	logic                       v_s1;
	logic signed [PROD_W-1:0]   prod_s2;
	logic                       v_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] filtered_q;
	logic                       warming_q;
	logic                       saturated_q;

	logic        [ACC_W-1:0]        rnd;
	logic        [Q_W-1:0]          q;
	logic        [Q_W-SAMPLE_W:0]   hi;
	logic signed [SAMPLE_W-1:0]     res_val;
	logic                           res_sat;

	assign dp_sts.pipe_busy = v_s1 || v_s2;
	assign filtered   = filtered_q;
	assign warming_up = warming_q;
	assign saturated  = saturated_q;

	always_ff @(posedge clk) begin
		if (dp_cmd.dl_wr) begin
			dl_mem[dp_cmd.wr_slot] <= sample;
		end
		if (dp_cmd.rd_en) begin
			dl_s1 <= dl_mem[dp_cmd.rd_slot];
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.cf_wr && (32'(coef_index) < 32'(MAX_TAPS))) begin
			cf_mem[ADDR_W'(coef_index)] <= coef_value;
		end
		if (dp_cmd.rd_en) begin
			cf_s1 <= cf_mem[dp_cmd.rd_tap];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= dp_cmd.rd_en;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= dl_s1 * cf_s1;
		if (dp_cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + {{(ACC_W - PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
		end
	end

	always_comb begin
		rnd = acc_q + ACC_W'(1 << (FRAC_W - 1));
		q   = rnd[ACC_W-1:FRAC_W];
		hi  = q[Q_W-1:SAMPLE_W-1];
		if ((hi == '0) || (hi == '1)) begin
			res_val = q[SAMPLE_W-1:0];
			res_sat = 1'b0;
		end else if (q[Q_W-1]) begin
			res_val = {1'b1, {(SAMPLE_W - 1){1'b0}}};
			res_sat = 1'b1;
		end else begin
			res_val = {1'b0, {(SAMPLE_W - 1){1'b1}}};
			res_sat = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.res_ld) begin
			if (dp_cmd.res_warm) begin
				filtered_q  <= '0;
				warming_q   <= 1'b1;
				saturated_q <= 1'b0;
			end else begin
				filtered_q  <= res_val;
				warming_q   <= 1'b0;
				saturated_q <= res_sat;
			end
		end
	end

endmodule

### rtl/fir_filter_with_warmup_blanking_unit.sv
// A coefficient load leaves the input open; the next transaction may follow at once.
// A warm-up sample skips the tap walk; its blanked result loads once output is free.
// A filtered sample runs one multiply-accumulate per tap on the single multiplier,
// which walks both memories, then drains its read and product stages.
// Reset clears control state and sets the tap count to one; memories are not cleared.
module fir_filter_with_warmup_blanking_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic                               first_of_series,
	input  logic signed [fwb_pkg::SAMPLE_W-1:0] sample,
	input  logic        [fwb_pkg::IDX_W-1:0]    coef_index,
	input  logic signed [fwb_pkg::COEF_W-1:0]   coef_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [fwb_pkg::SAMPLE_W-1:0] filtered,
	output logic                               warming_up,
	output logic                               saturated,
	input  logic                               cfg_wr_en,
	input  logic [fwb_pkg::TAP_CNT_W-1:0]       cfg_wr_data
);
	import fwb_pkg::*;

	fwb_cmd_t dp_cmd;
	fwb_sts_t dp_sts;

	fwb_ctrl u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.cmd             (cmd),
		.first_of_series (first_of_series),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.dp_cmd          (dp_cmd),
		.dp_sts          (dp_sts)
	);

	fwb_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.dp_cmd     (dp_cmd),
		.dp_sts     (dp_sts),
		.sample     (sample),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.filtered   (filtered),
		.warming_up (warming_up),
		.saturated  (saturated)
	);

	a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |-> !dp_sts.pipe_busy)
		else $error("Transaction accepted while the multiply pipeline is busy.");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.res_ld |-> !(out_valid && out_stall))
		else $error("Pending result overwritten.");

	a_rd_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.rd_en |-> in_stall && !dp_cmd.dl_wr)
		else $error("Tap read issued while input is open.");

	a_warm_blank: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && warming_up |-> (filtered == '0) && !saturated)
		else $error("Warm-up result is not blanked.");

endmodule

### tb/sv/fir_filter_with_warmup_blanking_unit_tb.sv
`timescale 1ns / 1ps

module fir_filter_with_warmup_blanking_unit_tb;
	import fwb_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_REPORTS = 10;
	localparam int SAMPLE_MAX  = (1 << (SAMPLE_W - 1)) - 1;
	localparam int SAMPLE_MIN  = -(1 << (SAMPLE_W - 1));
	localparam int COEF_MAX    = (1 << (COEF_W - 1)) - 1;
	localparam int COEF_MIN    = -(1 << (COEF_W - 1));

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       warming_up;
		logic                       saturated;
	} fir_result_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic                       cmd = CMD_SAMPLE;
	logic                       first_of_series = 1'b0;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic [IDX_W-1:0]           coef_index = '0;
	logic signed [COEF_W-1:0]   coef_value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       warming_up;
	logic                       saturated;
	logic                       cfg_wr_en = 1'b0;
	logic [TAP_CNT_W-1:0]       cfg_wr_data = '0;

	logic signed [COEF_W-1:0]   coef_mem [MAX_TAPS];
	logic signed [SAMPLE_W-1:0] delay_mem [MAX_TAPS];
	int                         wr_slot;
	int                         seen_count;
	logic [TAP_CNT_W-1:0]       tap_reg;
	fir_result_t                pending_results [$];

	bit no_idle = 1'b0;
	bit hold_wanted = 1'b0;
	bit hold_taken = 1'b0;
	int hold_left = 0;
	int cycle_count = 0;
	int mismatches = 0;
	int items_sent = 0;
	int results_checked = 0;
	int warm_results = 0;
	int sat_results = 0;

	fir_filter_with_warmup_blanking_unit i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.first_of_series(first_of_series),
		.sample         (sample),
		.coef_index     (coef_index),
		.coef_value     (coef_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.filtered       (filtered),
		.warming_up     (warming_up),
		.saturated      (saturated),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void predict_item(input logic op, input logic restart,
			input logic signed [SAMPLE_W-1:0] smp, input logic [IDX_W-1:0] idx,
			input logic signed [COEF_W-1:0] val);
		fir_result_t r;
		int          taps;
		longint      acc;
		longint      q;
		if (op == CMD_LOAD) begin
			coef_mem[idx] = val;
			return;
		end
		if (restart)
			seen_count = 0;
		delay_mem[wr_slot] = smp;
		if (seen_count < MAX_TAPS)
			seen_count++;
		if (tap_reg == 0)
			taps = 1;
		else if (tap_reg > MAX_TAPS)
			taps = MAX_TAPS;
		else
			taps = int'(tap_reg);
		r = '0;
		if (seen_count < taps) begin
			r.warming_up = 1'b1;
		end else begin
			acc = 0;
			for (int m = 0; m < taps; m++)
				acc += longint'(coef_mem[m]) *
					longint'(delay_mem[(wr_slot + MAX_TAPS - m) % MAX_TAPS]);
			q = (acc + 65536) >>> FRAC_W;
			if (q > SAMPLE_MAX) begin
				q = SAMPLE_MAX;
				r.saturated = 1'b1;
			end else if (q < SAMPLE_MIN) begin
				q = SAMPLE_MIN;
				r.saturated = 1'b1;
			end
			r.filtered = q[SAMPLE_W-1:0];
		end
		wr_slot = (wr_slot + 1) % MAX_TAPS;
		pending_results.push_back(r);
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] random_sample();
		int unsigned pick;
		pick = $urandom_range(9);
		if (pick == 0)
			return $urandom_range(1) ? SAMPLE_W'(SAMPLE_MAX) : SAMPLE_W'(SAMPLE_MIN);
		if (pick < 5)
			return SAMPLE_W'($urandom_range(16383) - 8192);
		return SAMPLE_W'($urandom);
	endfunction

	task automatic send_item(input logic op, input logic restart,
			input logic signed [SAMPLE_W-1:0] smp, input logic [IDX_W-1:0] idx,
			input logic signed [COEF_W-1:0] val);
		while (!no_idle && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		cmd             <= op;
		first_of_series <= restart;
		sample          <= smp;
		coef_index      <= idx;
		coef_value      <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_item(op, restart, smp, idx, val);
		items_sent++;
	endtask

	task automatic send_sample(input logic restart, input logic signed [SAMPLE_W-1:0] smp);
		send_item(CMD_SAMPLE, restart, smp, IDX_W'($urandom), COEF_W'($urandom));
	endtask

	task automatic load_coef(input logic [IDX_W-1:0] idx, input logic signed [COEF_W-1:0] val);
		send_item(CMD_LOAD, 1'($urandom_range(1)), SAMPLE_W'($urandom), idx, val);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic set_tap_count(input logic [TAP_CNT_W-1:0] taps);
		drain_results();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= taps;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tap_reg = taps;
	endtask

	task automatic test_single_tap();
		set_tap_count('0);
		load_coef('0, COEF_W'(COEF_MIN));
		send_sample(1'b1, SAMPLE_W'(SAMPLE_MIN));
		send_sample(1'b0, SAMPLE_W'(SAMPLE_MAX));
		load_coef('0, COEF_W'(1));
		send_sample(1'b0, SAMPLE_W'(65536));
		send_sample(1'b0, SAMPLE_W'(-65536));
		send_sample(1'b0, SAMPLE_W'(-65537));
		load_coef('0, COEF_W'(COEF_MAX));
		send_sample(1'b0, SAMPLE_W'(SAMPLE_MAX));
	endtask

	task automatic test_warmup_and_restart();
		set_tap_count(TAP_CNT_W'(4));
		for (int i = 1; i < 8; i++)
			load_coef(IDX_W'(i), COEF_W'($urandom_range(4095) - 2048));
		send_sample(1'b1, random_sample());
		repeat (4) send_sample(1'b0, random_sample());
		send_sample(1'b1, random_sample());
		send_item(CMD_LOAD, 1'b1, SAMPLE_W'($urandom), IDX_W'(7), COEF_W'($urandom));
		repeat (4) send_sample(1'b0, random_sample());
	endtask

	task automatic test_saturation();
		set_tap_count(TAP_CNT_W'(2));
		load_coef(IDX_W'(0), COEF_W'(COEF_MIN));
		load_coef(IDX_W'(1), COEF_W'(COEF_MIN));
		send_sample(1'b1, SAMPLE_W'(SAMPLE_MIN));
		repeat (2) send_sample(1'b0, SAMPLE_W'(SAMPLE_MIN));
		load_coef(IDX_W'(0), COEF_W'(COEF_MAX));
		load_coef(IDX_W'(1), COEF_W'(COEF_MAX));
		repeat (2) send_sample(1'b0, SAMPLE_W'(SAMPLE_MIN));
		repeat (2) send_sample(1'b0, SAMPLE_W'(SAMPLE_MAX));
	endtask

	task automatic test_tap_change_mid_series();
		set_tap_count(TAP_CNT_W'(8));
		repeat (4) send_sample(1'b0, random_sample());
		set_tap_count(TAP_CNT_W'(2));
		repeat (2) send_sample(1'b0, random_sample());
		set_tap_count(TAP_CNT_W'(5));
		send_sample(1'b0, random_sample());
	endtask

	// Only warm-up results arise here, so the clamping of large tap counts is seen
	// without reading coefficients that were never loaded.
	task automatic test_max_taps();
		set_tap_count('1);
		send_sample(1'b1, random_sample());
		repeat (3) send_sample(1'b0, random_sample());
		set_tap_count(TAP_CNT_W'(MAX_TAPS + 1));
		repeat (2) send_sample(1'b0, random_sample());
		set_tap_count(TAP_CNT_W'(MAX_TAPS));
		repeat (2) send_sample(1'b0, random_sample());
	endtask

	task automatic test_random_phases();
		int pick;
		int taps_choice [8];
		taps_choice = '{0, 1, 2, 3, 4, 5, 7, 8};
		for (int phase = 0; phase < 6; phase++) begin
			set_tap_count(TAP_CNT_W'(taps_choice[$urandom_range(7)]));
			no_idle = (phase == 2);
			repeat (10) begin
				pick = $urandom_range(99);
				if (pick < 18)
					load_coef(IDX_W'($urandom), COEF_W'($urandom));
				else if (pick < 24)
					send_sample(1'b1, random_sample());
				else
					send_sample(1'b0, random_sample());
			end
		end
		no_idle = 1'b0;
	endtask

	task automatic test_backpressure();
		set_tap_count(TAP_CNT_W'(3));
		hold_wanted = 1'b1;
		repeat (20) send_sample($urandom_range(19) == 0, random_sample());
		drain_results();
		repeat (10) send_sample($urandom_range(19) == 0, random_sample());
	endtask

	// The receiver stalls at random unless no_idle is set, apart from one long hold-off that fills the block.
	always @(posedge clk) begin
		if (hold_wanted && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !no_idle && ($urandom_range(99) < 10);
		end
	end

	// Each result transaction is checked against the oldest prediction.
	always @(posedge clk) begin
		fir_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result: filtered=%0d warming_up=%0b saturated=%0b",
						filtered, warming_up, saturated);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				warm_results += want.warming_up;
				sat_results += want.saturated;
				if (filtered !== want.filtered || warming_up !== want.warming_up ||
						saturated !== want.saturated) begin
					if (mismatches < MAX_REPORTS)
						$display("result %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b",
							results_checked, want.filtered, want.warming_up,
							want.saturated, filtered, warming_up, saturated);
					mismatches++;
				end
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		foreach (delay_mem[i]) begin
			delay_mem[i] = '0;
			coef_mem[i] = '0;
		end
		wr_slot = 0;
		seen_count = 0;
		tap_reg = TAP_CNT_W'(1);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_single_tap();
		test_warmup_and_restart();
		test_saturation();
		test_tap_change_mid_series();
		test_max_taps();
		test_random_phases();
		test_backpressure();
		drain_results();
		mismatches += pending_results.size();
		$display("Sent %0d transactions into the filter and checked %0d results.",
			items_sent, results_checked);
		$display("Results included %0d warm-up blanks and %0d clipped sums over tap counts 0 to 8191.",
			warm_results, sat_results);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
